@@ sv/cdc_pkg.sv @@
// Package for the calendar date counter: field widths, codes, reset date,
// month length table and constant helpers. No dependencies.
package cdc_pkg;

    localparam int OP_W          = 3;
    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int FIELD_YEAR_W  = 16;
    localparam int FIELD_COUNT_W = 16;
    localparam int STATUS_W      = 2;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam int DEF_YEAR_WIDTH  = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [DAY_W-1:0]        RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0]      RESET_MONTH = 4'd1;
    localparam logic [FIELD_YEAR_W-1:0] RESET_YEAR  = 16'd1981;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAYS_DEC  = 5'd31;

    // Centuries: y % 100 == 0 is y % 4 == 0 and y % 25 == 0
    localparam int CENTURY_ODD_FACTOR = 25;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD       = 3'd0,
        OP_ADD_DAYS   = 3'd1,
        OP_SUB_DAYS   = 3'd2,
        OP_ADD_MONTHS = 3'd3,
        OP_ADD_YEARS  = 3'd4,
        OP_COMPARE    = 3'd5,
        OP_RESET      = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STEP,
        S_MFIN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_DEFAULT_DAY   = 2'd0,
        REG_DEFAULT_MONTH = 2'd1,
        REG_DEFAULT_YEAR  = 2'd2
    } reg_idx_t;

    // Length of a month; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Multiplicative inverse of an odd constant modulo 2^32 (Newton steps)
    function automatic logic [31:0] odd_inverse(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV_CENTURY_ODD = odd_inverse(32'(CENTURY_ODD_FACTOR));

endpackage

@@ sv/cdc_req_if.sv @@
// Request channel of the calendar date counter: valid/ready plus payload.
// Depends on cdc_pkg for the field widths.
interface cdc_req_if
    import cdc_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic [OP_W-1:0]                 opcode;
    logic [DAY_W-1:0]                day_in;
    logic [MONTH_W-1:0]              month_in;
    logic [FIELD_YEAR_W-1:0]         year_in;
    logic signed [FIELD_COUNT_W-1:0] step_count;

    modport source (output valid, opcode, day_in, month_in, year_in, step_count,
                    input ready);
    modport sink   (input valid, opcode, day_in, month_in, year_in, step_count,
                    output ready);
endinterface

@@ sv/cdc_rsp_if.sv @@
// Response channel of the calendar date counter: valid/ready plus payload.
// Depends on cdc_pkg for the field widths.
interface cdc_rsp_if
    import cdc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [DAY_W-1:0]        day_out;
    logic [MONTH_W-1:0]      month_out;
    logic [FIELD_YEAR_W-1:0] year_out;
    logic [STATUS_W-1:0]     status;
    logic                    is_less;
    logic                    is_greater;
    logic                    differs;

    modport source (output valid, day_out, month_out, year_out, status,
                    is_less, is_greater, differs,
                    input ready);
    modport sink   (input valid, day_out, month_out, year_out, status,
                    is_less, is_greater, differs,
                    output ready);
endinterface

@@ sv/calendar_date_counter.sv @@
// Calendar date counter top level: sequencer, shared day-step unit, APB registers.
// Depends on cdc_pkg, cdc_req_if and cdc_rsp_if.
//
// Keeps one Gregorian date and applies one request at a time. A request is
// taken when req.valid and req.ready are high; its result appears in an output
// register, and the next request is taken in the same cycle that result is
// registered. Load, reset to default, compare, year add, no-op and day or
// month add or day subtract with a count of zero or less go from S_EXEC
// straight to S_DONE. Month add with a positive count forms the year carry
// by a reciprocal multiply in S_EXEC, and the remainder and year saturation
// in S_MFIN. Day add and subtract with a positive count pass through S_STEP,
// where a single day-step unit advances the date by one day per cycle until
// the count runs out or the year saturates. No request is taken before the
// last result is handed over, and a result left waiting stalls only the
// request after next. The leap test uses one shared multiplier (divisibility
// by 25 through a modular inverse) whose input is the loaded year, the default
// year or the current year, as the step requires. Defaults lie at byte
// addresses 0 (day), 4 (month) and 8 (year); write them only while no request
// is in flight. There is no clearing pass.
module calendar_date_counter
    import cdc_pkg::*;
#(
    parameter int YEAR_WIDTH  = DEF_YEAR_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)(
    input  logic                  clk,
    input  logic                  rst_n,
    cdc_req_if.sink               req,
    cdc_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int YW     = YEAR_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int WIDE_W = ((YW > CW) ? YW : CW) + 2;

    localparam logic [YW-1:0]     YEAR_MAX   = {YW{1'b1}};
    localparam logic [WIDE_W-1:0] YEAR_MAX_W = {{(WIDE_W-YW){1'b0}}, {YW{1'b1}}};
    localparam logic [YW-1:0]     INV25      = INV_CENTURY_ODD[YW-1:0];
    localparam logic [YW-1:0]     LIM25      =
        YW'(((64'd1 << YW) - 64'd1) / CENTURY_ODD_FACTOR);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DAY_W-1:0]        dflt_day_reg;
    logic [MONTH_W-1:0]      dflt_month_reg;
    logic [FIELD_YEAR_W-1:0] dflt_year_reg;
    logic                    cfg_write;
    reg_idx_t                cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_day_reg   <= RESET_DAY;
            dflt_month_reg <= RESET_MONTH;
            dflt_year_reg  <= RESET_YEAR;
        end
        else if (cfg_write)
        begin
            // Writes beyond the register list fall through and are dropped
            unique case (cfg_idx)
                REG_DEFAULT_DAY:   dflt_day_reg   <= pwdata[DAY_W-1:0];
                REG_DEFAULT_MONTH: dflt_month_reg <= pwdata[MONTH_W-1:0];
                REG_DEFAULT_YEAR:  dflt_year_reg  <= pwdata[FIELD_YEAR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DEFAULT_DAY:   prdata = APB_DATA_W'(dflt_day_reg);
            REG_DEFAULT_MONTH: prdata = APB_DATA_W'(dflt_month_reg);
            REG_DEFAULT_YEAR:  prdata = APB_DATA_W'(dflt_year_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // State and request registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [DAY_W-1:0]   cur_day_reg, cur_day_next;
    logic [MONTH_W-1:0] cur_month_reg, cur_month_next;
    logic [YW-1:0]      cur_year_reg, cur_year_next;

    logic [OP_W-1:0]    op_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YW-1:0]      year_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      quot_reg, quot_next;

    status_t status_reg, status_next;
    logic    lt_reg, lt_next;
    logic    gt_reg, gt_next;
    logic    ne_reg, ne_next;

    logic                    out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]        out_day_reg;
    logic [MONTH_W-1:0]      out_month_reg;
    logic [FIELD_YEAR_W-1:0] out_year_reg;
    status_t                 out_status_reg;
    logic                    out_lt_reg, out_gt_reg, out_ne_reg;

    logic slot_free;
    logic req_ready;
    logic req_accept;
    logic out_load;

    // Zero-extend the request fields, then cut them to the internal widths
    logic [31:0] year_in32;
    logic [31:0] cnt_in32;
    logic [31:0] dflt_year32;
    logic [31:0] cur_year32;
    logic [YW-1:0] dflt_year_w;

    assign year_in32   = 32'(req.year_in);
    assign cnt_in32    = {{(32-FIELD_COUNT_W){1'b0}}, req.step_count};
    assign dflt_year32 = 32'(dflt_year_reg);
    assign dflt_year_w = dflt_year32[YW-1:0];
    assign cur_year32  = 32'(cur_year_reg);

    assign slot_free  = !out_valid_reg || rsp.ready;
    assign req_ready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && slot_free);
    assign req_accept = req.valid && req_ready;
    assign req.ready  = req_ready;

    // ------------------------------------------------------------------
    // Shared leap test: Gregorian rule through divisibility by 4, 16, 25
    // ------------------------------------------------------------------
    logic [YW-1:0] leap_year;
    logic [YW-1:0] leap_prod;
    logic          div25;
    logic          leap;

    always_comb
    begin
        priority if ((state_reg == S_EXEC) && (op_t'(op_reg) == OP_LOAD))
            leap_year = year_reg;
        else if ((state_reg == S_EXEC) && (op_t'(op_reg) == OP_RESET))
            leap_year = dflt_year_w;
        else
            leap_year = cur_year_reg;
    end

    assign leap_prod = leap_year * INV25;
    assign div25     = (leap_prod <= LIM25);
    assign leap      = (leap_year[1:0] == 2'b00) && (!div25 || (leap_year[3:0] == 4'b0000));

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                     cnt_pos;
    logic [CW-1:0]            month_total;
    logic [CW-1:0]            month_quarter;
    logic [63:0]              recip_prod;
    logic [63:0]              recip_quot;
    logic [CW-1:0]            month_rem;
    logic [WIDE_W-1:0]        month_year;
    logic signed [WIDE_W-1:0] year_sum;
    logic [DAY_W-1:0]         len_cur;
    logic [DAY_W-1:0]         len_prev;
    logic [DAY_W-1:0]         len_load;
    logic [DAY_W-1:0]         len_dflt;
    logic                     load_ok;
    logic                     dflt_ok;

    assign cnt_pos = !cnt_reg[CW-1] && (cnt_reg != '0);

    // Month add: months past January plus the count, split by twelve
    assign month_total   = CW'(cur_month_reg) - CW'(MONTH_JAN) + cnt_reg;
    assign month_quarter = month_total >> 2;
    assign recip_prod    = 64'(32'(month_quarter)) * 64'(RECIP3);
    assign recip_quot    = recip_prod >> RECIP3_SHIFT;
    assign month_rem     = month_total - (quot_reg << 3) - (quot_reg << 2);
    assign month_year    = WIDE_W'(cur_year_reg) + WIDE_W'(quot_reg);

    assign year_sum = signed'(WIDE_W'(cur_year_reg)) + WIDE_W'(signed'(cnt_reg));

    assign len_cur  = days_in(cur_month_reg, leap);
    assign len_prev = days_in(cur_month_reg - MONTH_JAN, leap);
    assign len_load = days_in(month_reg, leap);
    assign len_dflt = days_in(dflt_month_reg, leap);

    assign load_ok = (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC)
                  && (day_reg != '0) && (day_reg <= len_load);
    assign dflt_ok = (dflt_month_reg >= MONTH_JAN) && (dflt_month_reg <= MONTH_DEC)
                  && (dflt_day_reg != '0) && (dflt_day_reg <= len_dflt);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        cnt_next       = req_accept ? cnt_in32[CW-1:0] : cnt_reg;
        quot_next      = quot_reg;
        status_next    = status_reg;
        lt_next        = lt_reg;
        gt_next        = gt_reg;
        ne_next        = ne_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                lt_next     = 1'b0;
                gt_next     = 1'b0;
                ne_next     = 1'b0;
                state_next  = S_DONE;
                unique case (op_t'(op_reg))
                    OP_LOAD:
                    begin
                        if (load_ok)
                        begin
                            cur_day_next   = day_reg;
                            cur_month_next = month_reg;
                            cur_year_next  = year_reg;
                        end
                        else
                            status_next = ST_INVALID;
                    end
                    OP_ADD_DAYS, OP_SUB_DAYS:
                    begin
                        // Zero or negative counts act as no change
                        if (cnt_pos)
                            state_next = S_STEP;
                    end
                    OP_ADD_MONTHS:
                    begin
                        if (cnt_pos)
                        begin
                            quot_next  = CW'(recip_quot);
                            state_next = S_MFIN;
                        end
                    end
                    OP_ADD_YEARS:
                    begin
                        if (year_sum < 0)
                        begin
                            cur_year_next = '0;
                            status_next   = ST_SATURATED;
                        end
                        else if (year_sum > signed'(YEAR_MAX_W))
                        begin
                            cur_year_next = YEAR_MAX;
                            status_next   = ST_SATURATED;
                        end
                        else
                            cur_year_next = year_sum[YW-1:0];
                    end
                    OP_COMPARE:
                    begin
                        priority if (cur_year_reg != year_reg)
                        begin
                            lt_next = cur_year_reg < year_reg;
                            gt_next = cur_year_reg > year_reg;
                        end
                        else if (cur_month_reg != month_reg)
                        begin
                            lt_next = cur_month_reg < month_reg;
                            gt_next = cur_month_reg > month_reg;
                        end
                        else
                        begin
                            lt_next = cur_day_reg < day_reg;
                            gt_next = cur_day_reg > day_reg;
                        end
                        ne_next = lt_next || gt_next;
                    end
                    OP_RESET:
                    begin
                        if (dflt_ok)
                        begin
                            cur_day_next   = dflt_day_reg;
                            cur_month_next = dflt_month_reg;
                            cur_year_next  = dflt_year_w;
                        end
                        else
                            status_next = ST_INVALID;
                    end
                    default: ;
                endcase
            end

            S_STEP:
            begin
                // One day per cycle; stop early when the year would leave its range
                if (op_t'(op_reg) == OP_SUB_DAYS)
                begin
                    if (cur_day_reg <= 5'd1)
                    begin
                        if (cur_month_reg <= MONTH_JAN)
                        begin
                            if (cur_year_reg == '0)
                                status_next = ST_SATURATED;
                            else
                            begin
                                cur_year_next  = cur_year_reg - 1'b1;
                                cur_month_next = MONTH_DEC;
                                cur_day_next   = DAYS_DEC;
                            end
                        end
                        else
                        begin
                            cur_month_next = cur_month_reg - MONTH_JAN;
                            cur_day_next   = len_prev;
                        end
                    end
                    else
                        cur_day_next = cur_day_reg - 1'b1;
                end
                else
                begin
                    if (cur_day_reg >= len_cur)
                    begin
                        if (cur_month_reg == MONTH_DEC)
                        begin
                            if (cur_year_reg == YEAR_MAX)
                                status_next = ST_SATURATED;
                            else
                            begin
                                cur_year_next  = cur_year_reg + 1'b1;
                                cur_month_next = MONTH_JAN;
                                cur_day_next   = 5'd1;
                            end
                        end
                        else
                        begin
                            cur_month_next = cur_month_reg + 1'b1;
                            cur_day_next   = 5'd1;
                        end
                    end
                    else
                        cur_day_next = cur_day_reg + 1'b1;
                end

                cnt_next = cnt_reg - 1'b1;
                if ((status_next == ST_SATURATED) || (cnt_reg == CW'(1)))
                    state_next = S_DONE;
            end

            S_MFIN:
            begin
                cur_month_next = month_rem[MONTH_W-1:0] + MONTH_JAN;
                if (month_year > YEAR_MAX_W)
                begin
                    cur_year_next = YEAR_MAX;
                    status_next   = ST_SATURATED;
                end
                else
                    cur_year_next = month_year[YW-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result over and take the next request in the same cycle
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = req_accept ? S_EXEC : S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_day_reg   <= RESET_DAY;
            cur_month_reg <= RESET_MONTH;
            cur_year_reg  <= YW'(RESET_YEAR);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg    <= req.opcode;
            day_reg   <= req.day_in;
            month_reg <= req.month_in;
            year_reg  <= year_in32[YW-1:0];
        end
        cnt_reg    <= cnt_next;
        quot_reg   <= quot_next;
        status_reg <= status_next;
        lt_reg     <= lt_next;
        gt_reg     <= gt_next;
        ne_reg     <= ne_next;
        if (out_load)
        begin
            out_day_reg    <= cur_day_reg;
            out_month_reg  <= cur_month_reg;
            out_year_reg   <= cur_year32[FIELD_YEAR_W-1:0];
            out_status_reg <= status_reg;
            out_lt_reg     <= lt_reg;
            out_gt_reg     <= gt_reg;
            out_ne_reg     <= ne_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.day_out    = out_day_reg;
    assign rsp.month_out  = out_month_reg;
    assign rsp.year_out   = out_year_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.is_less    = out_lt_reg;
    assign rsp.is_greater = out_gt_reg;
    assign rsp.differs    = out_ne_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_DEC))
        else $error("current month left the range 1 to 12");

    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_day_reg != '0)
        else $error("current day became zero");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (cnt_reg != '0) && !cnt_reg[CW-1])
        else $error("day stepping with no positive count left");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result registered outside the done state");
`endif

endmodule
